FILE: sv/axis_vector_rotation_core_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef AXIS_VECTOR_ROTATION_CORE_ASSERT_SVH
`define AXIS_VECTOR_ROTATION_CORE_ASSERT_SVH

// The consequent must hold at every edge at which the antecedent holds.
`define AVR_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("axis_vector_rotation_core: assertion failed");

// The expression must never hold outside of reset.
`define AVR_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("axis_vector_rotation_core: forbidden condition seen");

`endif

FILE: sv/avr_pkg.sv
package avr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 16;
  localparam int ATAN_COUNT    = 30;
  localparam int KGAIN_Q30     = 652032875;

  localparam int VEC_W      = 32;
  localparam int ANGLE_W    = 16;
  localparam int Z_W        = 32;
  localparam int CS_W       = FRAC_BITS + 3;
  localparam int PROD_W     = VEC_W + CS_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int IDX_W      = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int ATAN_IDX_W = $clog2(ATAN_COUNT);

  // Cells, then quadrant select, product stage and output register.
  localparam int LATENCY = CORDIC_STAGES + 3;

  localparam int C_INIT = (KGAIN_Q30 + (1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [Z_W-1:0] ATAN_TURN [ATAN_COUNT] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef enum logic [1:0] {
    AXIS_Z    = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_NONE = 2'd3
  } avr_axis_e;

  // Request payload that rides along the cell chain.
  typedef struct packed {
    avr_axis_e               axis;
    logic [1:0]              quad;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;
  } avr_item_t;

endpackage

FILE: sv/axis_vector_rotation_core.sv
// Rotates a Q16.16 vector about the z, x or y axis by an angle given in
// 65536 units per full turn.
// Request channel: a request is taken at a rising edge with start_i high and
// busy_o low. busy_o is always low, so a new request may enter every cycle.
// Result channel: valid_o is high for exactly one cycle per request, with
// rx_o, ry_o, rz_o and overflow_o valid in that same cycle. Results leave
// in request order and cannot be held off by the receiver.
// A request passes through the CORDIC cells in turn, then the quadrant
// select, the product stage and the rounding/saturation register.
// Throughput: one request per cycle, set by the fully pipelined cell chain
// and the four multipliers behind it.
// Reset: rst_ni clears all valid flags at once; requests in flight are lost
// and no result is issued for them. No memory needs a clearing pass.
// cmd 3 passes the vector through unchanged with overflow_o low.
module axis_vector_rotation_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           cmd_i,
  input  logic signed [avr_pkg::VEC_W-1:0]     vx_i,
  input  logic signed [avr_pkg::VEC_W-1:0]     vy_i,
  input  logic signed [avr_pkg::VEC_W-1:0]     vz_i,
  input  logic [avr_pkg::ANGLE_W-1:0]          turn_angle_i,
  output logic                                 valid_o,
  output logic signed [avr_pkg::VEC_W-1:0]     rx_o,
  output logic signed [avr_pkg::VEC_W-1:0]     ry_o,
  output logic signed [avr_pkg::VEC_W-1:0]     rz_o,
  output logic                                 overflow_o
);

  localparam int N = avr_pkg::CORDIC_STAGES;

  logic [avr_pkg::ANGLE_W:0]         quad_sum;
  logic [1:0]                        quad;
  logic [avr_pkg::ANGLE_W-1:0]       resid;

  logic                              chain_vld  [N+1];
  logic signed [avr_pkg::CS_W-1:0]   chain_c    [N+1];
  logic signed [avr_pkg::CS_W-1:0]   chain_s    [N+1];
  logic signed [avr_pkg::Z_W-1:0]    chain_z    [N+1];
  avr_pkg::avr_item_t                chain_item [N+1];

  assign busy_o = 1'b0;

  // Nearest quarter turn and the signed residual left after removing it.
  assign quad_sum = {1'b0, turn_angle_i} + (avr_pkg::ANGLE_W + 1)'(16'h2000);
  assign quad     = quad_sum[avr_pkg::ANGLE_W-1:avr_pkg::ANGLE_W-2];
  assign resid    = turn_angle_i - {quad, {(avr_pkg::ANGLE_W - 2){1'b0}}};

  assign chain_vld[0]       = start_i & ~busy_o;
  assign chain_c[0]         = avr_pkg::CS_W'(avr_pkg::C_INIT);
  assign chain_s[0]         = '0;
  assign chain_z[0]         = {resid, {(avr_pkg::Z_W - avr_pkg::ANGLE_W){1'b0}}};
  assign chain_item[0].axis = avr_pkg::avr_axis_e'(cmd_i);
  assign chain_item[0].quad = quad;
  assign chain_item[0].vx   = vx_i;
  assign chain_item[0].vy   = vy_i;
  assign chain_item[0].vz   = vz_i;

  for (genvar g = 0; g < N; g++) begin : g_cell
    avr_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (avr_pkg::IDX_W'(g)),
      .valid_i (chain_vld[g]),
      .c_i     (chain_c[g]),
      .s_i     (chain_s[g]),
      .z_i     (chain_z[g]),
      .item_i  (chain_item[g]),
      .valid_o (chain_vld[g+1]),
      .c_o     (chain_c[g+1]),
      .s_o     (chain_s[g+1]),
      .z_o     (chain_z[g+1]),
      .item_o  (chain_item[g+1])
    );
  end

  avr_rotate u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (chain_vld[N]),
    .c_i        (chain_c[N]),
    .s_i        (chain_s[N]),
    .item_i     (chain_item[N]),
    .valid_o    (valid_o),
    .rx_o       (rx_o),
    .ry_o       (ry_o),
    .rz_o       (rz_o),
    .overflow_o (overflow_o)
  );

endmodule

FILE: sv/avr_cordic_cell.sv
module avr_cordic_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [avr_pkg::IDX_W-1:0]          stage_i,
  input  logic                               valid_i,
  input  logic signed [avr_pkg::CS_W-1:0]    c_i,
  input  logic signed [avr_pkg::CS_W-1:0]    s_i,
  input  logic signed [avr_pkg::Z_W-1:0]     z_i,
  input  avr_pkg::avr_item_t                 item_i,
  output logic                               valid_o,
  output logic signed [avr_pkg::CS_W-1:0]    c_o,
  output logic signed [avr_pkg::CS_W-1:0]    s_o,
  output logic signed [avr_pkg::Z_W-1:0]     z_o,
  output avr_pkg::avr_item_t                 item_o
);

  logic                            valid_q;
  logic signed [avr_pkg::CS_W-1:0] c_q, c_d;
  logic signed [avr_pkg::CS_W-1:0] s_q, s_d;
  logic signed [avr_pkg::Z_W-1:0]  z_q, z_d;
  avr_pkg::avr_item_t              item_q;
  logic signed [avr_pkg::CS_W-1:0] dc, ds;
  logic signed [avr_pkg::Z_W-1:0]  atan_step;

  assign dc        = s_i >>> stage_i;
  assign ds        = c_i >>> stage_i;
  assign atan_step = $signed(avr_pkg::ATAN_TURN[avr_pkg::ATAN_IDX_W'(stage_i)]);

  always_comb begin
    if (!z_i[avr_pkg::Z_W-1]) begin
      c_d = c_i - dc;
      s_d = s_i + ds;
      z_d = z_i - atan_step;
    end else begin
      c_d = c_i + dc;
      s_d = s_i - ds;
      z_d = z_i + atan_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    s_q    <= s_d;
    z_q    <= z_d;
    item_q <= item_i;
  end

  assign valid_o = valid_q;
  assign c_o     = c_q;
  assign s_o     = s_q;
  assign z_o     = z_q;
  assign item_o  = item_q;

endmodule

FILE: sv/avr_rotate.sv
module avr_rotate (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [avr_pkg::CS_W-1:0]    c_i,
  input  logic signed [avr_pkg::CS_W-1:0]    s_i,
  input  avr_pkg::avr_item_t                 item_i,
  output logic                               valid_o,
  output logic signed [avr_pkg::VEC_W-1:0]   rx_o,
  output logic signed [avr_pkg::VEC_W-1:0]   ry_o,
  output logic signed [avr_pkg::VEC_W-1:0]   rz_o,
  output logic                               overflow_o
);

  localparam int SW = avr_pkg::SUM_W;
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW - 32){1'b0}}, 32'h7fffffff};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW - 32){1'b1}}, 32'h80000000};
  localparam logic signed [SW-1:0] RND     = SW'(1) <<< (avr_pkg::FRAC_BITS - 1);

  // Quadrant stage.
  logic                             vld_a_q;
  logic signed [avr_pkg::CS_W-1:0]  co_q, co_d, si_q, si_d;
  logic signed [avr_pkg::VEC_W-1:0] p_q, p_d, m_q, m_d;
  avr_pkg::avr_item_t               item_a_q;

  // Product stage.
  logic                              vld_b_q;
  logic signed [avr_pkg::PROD_W-1:0] pc_q, ms_q, ps_q, mc_q;
  avr_pkg::avr_item_t                item_b_q;

  // Output stage.
  logic                             valid_q;
  logic signed [avr_pkg::VEC_W-1:0] rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  logic                             ovf_q, ovf_d;

  logic signed [SW-1:0]             sum1, sum2, r1, r2;
  logic signed [avr_pkg::VEC_W-1:0] o1, o2;
  logic                             ovf1, ovf2;

  always_comb begin
    case (item_i.quad)
      2'd0: begin
        co_d = c_i;
        si_d = s_i;
      end
      2'd1: begin
        co_d = -s_i;
        si_d = c_i;
      end
      2'd2: begin
        co_d = -c_i;
        si_d = -s_i;
      end
      default: begin
        co_d = s_i;
        si_d = -c_i;
      end
    endcase
  end

  // The two rotated components are o1 = p*c - m*s and o2 = p*s + m*c.
  always_comb begin
    case (item_i.axis)
      avr_pkg::AXIS_Z: begin
        p_d = item_i.vx;
        m_d = item_i.vy;
      end
      avr_pkg::AXIS_X: begin
        p_d = item_i.vy;
        m_d = item_i.vz;
      end
      avr_pkg::AXIS_Y: begin
        p_d = item_i.vz;
        m_d = item_i.vx;
      end
      default: begin
        p_d = item_i.vx;
        m_d = item_i.vy;
      end
    endcase
  end

  assign sum1 = SW'(pc_q) - SW'(ms_q);
  assign sum2 = SW'(ps_q) + SW'(mc_q);
  assign r1   = (sum1 + RND) >>> avr_pkg::FRAC_BITS;
  assign r2   = (sum2 + RND) >>> avr_pkg::FRAC_BITS;

  always_comb begin
    ovf1 = 1'b0;
    ovf2 = 1'b0;
    if (r1 > SAT_MAX) begin
      o1   = SAT_MAX[avr_pkg::VEC_W-1:0];
      ovf1 = 1'b1;
    end else if (r1 < SAT_MIN) begin
      o1   = SAT_MIN[avr_pkg::VEC_W-1:0];
      ovf1 = 1'b1;
    end else begin
      o1 = r1[avr_pkg::VEC_W-1:0];
    end
    if (r2 > SAT_MAX) begin
      o2   = SAT_MAX[avr_pkg::VEC_W-1:0];
      ovf2 = 1'b1;
    end else if (r2 < SAT_MIN) begin
      o2   = SAT_MIN[avr_pkg::VEC_W-1:0];
      ovf2 = 1'b1;
    end else begin
      o2 = r2[avr_pkg::VEC_W-1:0];
    end
  end

  always_comb begin
    rx_d  = item_b_q.vx;
    ry_d  = item_b_q.vy;
    rz_d  = item_b_q.vz;
    ovf_d = ovf1 | ovf2;
    case (item_b_q.axis)
      avr_pkg::AXIS_Z: begin
        rx_d = o1;
        ry_d = o2;
      end
      avr_pkg::AXIS_X: begin
        ry_d = o1;
        rz_d = o2;
      end
      avr_pkg::AXIS_Y: begin
        rz_d = o1;
        rx_d = o2;
      end
      default: begin
        ovf_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      valid_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    co_q     <= co_d;
    si_q     <= si_d;
    p_q      <= p_d;
    m_q      <= m_d;
    item_a_q <= item_i;
    pc_q     <= p_q * co_q;
    ms_q     <= m_q * si_q;
    ps_q     <= p_q * si_q;
    mc_q     <= m_q * co_q;
    item_b_q <= item_a_q;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    rz_q     <= rz_d;
    ovf_q    <= ovf_d;
  end

  assign valid_o    = valid_q;
  assign rx_o       = rx_q;
  assign ry_o       = ry_q;
  assign rz_o       = rz_q;
  assign overflow_o = ovf_q;

endmodule

FILE: sv/avr_checker.sv
`include "axis_vector_rotation_core_assert.svh"

module avr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic [1:0]                       cmd_i,
  input logic signed [avr_pkg::VEC_W-1:0] vx_i,
  input logic signed [avr_pkg::VEC_W-1:0] vy_i,
  input logic signed [avr_pkg::VEC_W-1:0] vz_i,
  input logic                             valid_o,
  input logic signed [avr_pkg::VEC_W-1:0] rx_o,
  input logic signed [avr_pkg::VEC_W-1:0] ry_o,
  input logic signed [avr_pkg::VEC_W-1:0] rz_o,
  input logic                             overflow_o
);

  localparam int L = avr_pkg::LATENCY;

  // Every result belongs to a request taken a fixed latency earlier.
  `AVR_ASSERT_IMPLIES(a_result_has_request, valid_o, $past(start_i && !busy_o, L))

  // An unused selector passes the vector through without overflow.
  `AVR_ASSERT_IMPLIES(a_pass_through, valid_o && $past(cmd_i, L) == avr_pkg::AXIS_NONE, rx_o == $past(vx_i, L) && ry_o == $past(vy_i, L) && rz_o == $past(vz_i, L) && !overflow_o)

  // For a rotation about z, the z component is untouched.
  `AVR_ASSERT_IMPLIES(a_axis_kept, valid_o && $past(cmd_i, L) == avr_pkg::AXIS_Z, rz_o == $past(vz_i, L))

  // Overflow is only raised with some component sitting at a limit.
  `AVR_ASSERT_IMPLIES(a_ovf_saturated, valid_o && overflow_o, rx_o == 32'sh7fffffff || rx_o == 32'sh80000000 || ry_o == 32'sh7fffffff || ry_o == 32'sh80000000 || rz_o == 32'sh7fffffff || rz_o == 32'sh80000000)

  // The pipeline takes a request in every cycle.
  `AVR_ASSERT_NEVER(a_never_busy, busy_o)

endmodule

bind axis_vector_rotation_core avr_checker u_avr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .cmd_i      (cmd_i),
  .vx_i       (vx_i),
  .vy_i       (vy_i),
  .vz_i       (vz_i),
  .valid_o    (valid_o),
  .rx_o       (rx_o),
  .ry_o       (ry_o),
  .rz_o       (rz_o),
  .overflow_o (overflow_o)
);
